// File: hdl/gfd_pkg.sv
// Shared constants, register codes and types for the gaze fixation detector.
// Used by gfd_div and by the top level gaze_fixation_dispersion_detector.
package gfd_pkg;

  localparam int WINDOW_DEPTH = 64;
  localparam int PTR_W        = $clog2(WINDOW_DEPTH);
  localparam int COORD_W      = 16;
  localparam int COUNT_W      = 16;
  localparam int SUM_W        = 2 * COORD_W;
  localparam int SPREAD_W     = COORD_W + 1;
  localparam int MINP_W       = 7;
  localparam int WIN_CNT_W    = PTR_W + 1;
  localparam int CFG_IDX_W    = 1;
  localparam int CFG_DATA_W   = 17;
  localparam int IN_DATA_W    = 2 * COORD_W;
  localparam int OUT_DATA_W   = 72;

  localparam logic [COUNT_W-1:0]    COUNT_MAX     = '1;
  localparam logic [MINP_W-1:0]     MINP_RESET    = MINP_W'(6);
  localparam logic [SPREAD_W-1:0]   MAXD_RESET    = SPREAD_W'(800);
  localparam logic [WIN_CNT_W-1:0]  WIN_FULL      = WIN_CNT_W'(WINDOW_DEPTH);

  // Configuration register indexes.
  localparam logic [CFG_IDX_W-1:0] REG_MIN_POINTS = 1'b0;
  localparam logic [CFG_IDX_W-1:0] REG_MAX_DISP   = 1'b1;

  // Status of the shared serial divider.
  typedef struct packed {
    logic busy;
    logic done;
  } div_status_t;

endpackage

// File: hdl/gfd_div.sv
// Serial restoring divider, one quotient bit per cycle, for the centroid.
// Depends on gfd_pkg. Requires the upper dividend half to be below the divisor.
module gfd_div (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           start_i,
  input  logic [gfd_pkg::SUM_W-1:0]      dividend_i,
  input  logic [gfd_pkg::COUNT_W-1:0]    divisor_i,
  output gfd_pkg::div_status_t           status_o,
  output logic [gfd_pkg::COORD_W-1:0]    quotient_o
);
  import gfd_pkg::*;

  localparam int STEP_W = $clog2(COORD_W + 1);

  logic [COORD_W-1:0] rem_q, rem_d;
  logic [COORD_W-1:0] quo_q, quo_d;
  logic [COUNT_W-1:0] dvs_q, dvs_d;
  logic [STEP_W-1:0]  step_q, step_d;
  logic               busy_q, busy_d;
  logic               done_q, done_d;
  logic [COORD_W:0]   trial;
  logic               fits;

  // The quotient is known to fit in COORD_W bits, so the upper half of the
  // dividend seeds the remainder and only the lower half is shifted in.
  assign trial = {rem_q, quo_q[COORD_W-1]};
  assign fits  = trial >= {1'b0, dvs_q};

  always_comb begin
    rem_d  = rem_q;
    quo_d  = quo_q;
    dvs_d  = dvs_q;
    step_d = step_q;
    busy_d = busy_q;
    done_d = 1'b0;
    if (start_i) begin
      rem_d  = dividend_i[SUM_W-1:COORD_W];
      quo_d  = dividend_i[COORD_W-1:0];
      dvs_d  = divisor_i;
      step_d = STEP_W'(COORD_W);
      busy_d = 1'b1;
    end else if (busy_q) begin
      rem_d  = fits ? COORD_W'(trial - {1'b0, dvs_q}) : trial[COORD_W-1:0];
      quo_d  = {quo_q[COORD_W-2:0], fits};
      step_d = step_q - STEP_W'(1);
      if (step_q == STEP_W'(1)) begin
        busy_d = 1'b0;
        done_d = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      step_q <= '0;
    end else begin
      busy_q <= busy_d;
      done_q <= done_d;
      step_q <= step_d;
    end
  end

  always_ff @(posedge clk_i) begin
    rem_q <= rem_d;
    quo_q <= quo_d;
    dvs_q <= dvs_d;
  end

  assign status_o.busy = busy_q;
  assign status_o.done = done_q;
  assign quotient_o    = quo_q;

  start_while_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    start_i |-> !busy_q)
    else $error("divider started while busy");

  done_ends_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_q |-> $past(busy_q) && !busy_q)
    else $error("divider done without a finished run");

  step_bounded: assert property (@(posedge clk_i) disable iff (!rst_ni)
    busy_q |-> step_q != '0)
    else $error("divider busy with no steps left");

endmodule

// File: hdl/gaze_fixation_dispersion_detector.sv
// Gaze fixation detector by dispersion threshold, top level.
// Depends on gfd_pkg and instantiates the serial divider gfd_div.
//
// Each input item carries one gaze point (x in tdata[15:0], y in tdata[31:16],
// unsigned Q12.4 pixels) and produces exactly one result item. Outside a
// fixation the points are kept in a 64-entry ring memory; once the window
// holds min_points points, a sequencer reads the window back one entry per
// cycle to find its extent and sums, and the dispersion (x range plus y
// range) is compared against max_dispersion. Inside a fixation each point
// only updates running extent, sums and a saturating count. Whenever the
// block is in a fixation after the test, the centroid is formed by one
// serial divider used twice, sixteen quotient bits each. The input is ready
// only in the idle state. An item in a fixation is taken, updates the
// cluster and is tested; while the fixation holds, both divisions follow
// before its result is loaded. An item outside a fixation is taken and
// pushed into the window; once the window is long enough to test, its
// entries (up to 64) are read back and tested, with both divisions after
// the test when a fixation is open, before the result is loaded. The
// result is held in an output register, so the next item is taken while
// the last result waits; a result that is still waiting when the next one
// is ready stalls the block.
// Configuration is written through cfg_we_i/cfg_idx_i/cfg_data_i while the
// block is idle; index 0 is min_points, index 1 is max_dispersion.
module gaze_fixation_dispersion_detector (
  input  logic                               clk_i,
  input  logic                               rst_ni,
  input  logic                               cfg_we_i,
  input  logic [gfd_pkg::CFG_IDX_W-1:0]      cfg_idx_i,
  input  logic [gfd_pkg::CFG_DATA_W-1:0]     cfg_data_i,
  input  logic                               s_axis_tvalid,
  output logic                               s_axis_tready,
  // tdata from bit 0 up: x_coord[15:0], y_coord[31:16]
  input  logic [gfd_pkg::IN_DATA_W-1:0]      s_axis_tdata,
  output logic                               m_axis_tvalid,
  input  logic                               m_axis_tready,
  // tdata from bit 0 up: spread[16:0], centre_x[32:17], centre_y[48:33],
  // cluster_size[64:49], zero fill[71:65]
  output logic [gfd_pkg::OUT_DATA_W-1:0]     m_axis_tdata,
  // tuser from bit 0 up: is_fixation[0]
  output logic [0:0]                         m_axis_tuser
);
  import gfd_pkg::*;

  localparam logic [2:0] S_IDLE = 3'd0;
  localparam logic [2:0] S_FIX  = 3'd1;
  localparam logic [2:0] S_PUSH = 3'd2;
  localparam logic [2:0] S_SCAN = 3'd3;
  localparam logic [2:0] S_TEST = 3'd4;
  localparam logic [2:0] S_DIVX = 3'd5;
  localparam logic [2:0] S_DIVY = 3'd6;
  localparam logic [2:0] S_DONE = 3'd7;

  localparam int PAD_W = OUT_DATA_W - SPREAD_W - 3 * COORD_W;

  // Configuration.
  logic [MINP_W-1:0]   minp_cfg_q;
  logic [SPREAD_W-1:0] maxd_cfg_q;
  logic [MINP_W-1:0]   minp;

  // Sequencer and detector state.
  logic [2:0]           state_q, state_d;
  logic [COORD_W-1:0]   x_q, x_d, y_q, y_d;
  logic [PTR_W-1:0]     head_q, head_d;
  logic [COUNT_W-1:0]   count_q, count_d;
  logic                 in_fix_q, in_fix_d;
  logic [COORD_W-1:0]   low_x_q, low_x_d, high_x_q, high_x_d;
  logic [COORD_W-1:0]   low_y_q, low_y_d, high_y_q, high_y_d;
  logic [SUM_W-1:0]     tot_x_q, tot_x_d, tot_y_q, tot_y_d;
  logic [WIN_CNT_W-1:0] idx_q, idx_d;
  logic                 first_q, first_d;
  logic                 rd_vld_q, rd_vld_d;
  logic                 flag_q, flag_d;
  logic [SPREAD_W-1:0]  spread_q, spread_d;
  logic [COORD_W-1:0]   cx_q, cx_d;

  // Output register.
  logic                 m_valid_q, m_valid_d;
  logic [OUT_DATA_W-1:0] m_data_q, m_data_d;
  logic                 m_user_q, m_user_d;

  // Ring memory, x in the low half and y in the high half of each entry.
  logic [IN_DATA_W-1:0] ring_mem [WINDOW_DEPTH];
  logic                 mem_we, mem_re;
  logic [PTR_W-1:0]     mem_waddr, mem_raddr;
  logic [IN_DATA_W-1:0] mem_wdata, rd_data_q;
  logic [COORD_W-1:0]   px, py;

  // Window bookkeeping helpers.
  logic                 win_wrap;
  logic [PTR_W-1:0]     push_head;
  logic [WIN_CNT_W-1:0] push_cnt;
  logic [WIN_CNT_W-1:0] push_new_cnt;
  logic                 scan_issue;
  logic [SPREAD_W-1:0]  range_sum;
  logic                 spread_ok;
  logic                 do_test;

  // Divider.
  logic                 div_start;
  logic [SUM_W-1:0]     div_dividend;
  div_status_t          div_st;
  logic [COORD_W-1:0]   div_quot;

  assign s_axis_tready = (state_q == S_IDLE);
  assign m_axis_tvalid = m_valid_q;
  assign m_axis_tdata  = m_data_q;
  assign m_axis_tuser  = m_user_q;

  // A minimum of zero acts as one and one above the ring depth acts as the depth.
  always_comb begin
    if (minp_cfg_q == '0) begin
      minp = MINP_W'(1);
    end else if (minp_cfg_q > MINP_W'(WINDOW_DEPTH)) begin
      minp = MINP_W'(WINDOW_DEPTH);
    end else begin
      minp = minp_cfg_q;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      minp_cfg_q <= MINP_RESET;
      maxd_cfg_q <= MAXD_RESET;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        REG_MIN_POINTS: minp_cfg_q <= cfg_data_i[MINP_W-1:0];
        REG_MAX_DISP:   maxd_cfg_q <= cfg_data_i[SPREAD_W-1:0];
        default:        ;
      endcase
    end
  end

  // Outside a fixation the count never exceeds the ring depth. A full ring
  // drops its oldest point before the new one is placed.
  assign win_wrap     = count_q[WIN_CNT_W-1:0] >= WIN_FULL;
  assign push_head    = win_wrap ? head_q + PTR_W'(1) : head_q;
  assign push_cnt     = win_wrap ? WIN_FULL - WIN_CNT_W'(1) : count_q[WIN_CNT_W-1:0];
  assign push_new_cnt = push_cnt + WIN_CNT_W'(1);

  assign scan_issue = (state_q == S_SCAN) && (idx_q < count_q[WIN_CNT_W-1:0]);
  assign px         = rd_data_q[COORD_W-1:0];
  assign py         = rd_data_q[IN_DATA_W-1:COORD_W];

  assign range_sum = SPREAD_W'(high_x_q - low_x_q) + SPREAD_W'(high_y_q - low_y_q);
  assign spread_ok = (range_sum != '0) && (range_sum <= maxd_cfg_q);
  assign do_test   = !in_fix_q || (count_q >= COUNT_W'(minp));

  // Memory port control.
  always_comb begin
    mem_we    = 1'b0;
    mem_waddr = push_head + push_cnt[PTR_W-1:0];
    mem_wdata = {y_q, x_q};
    if (state_q == S_PUSH) begin
      mem_we = 1'b1;
    end else if (state_q == S_TEST && in_fix_q && do_test && !spread_ok) begin
      // Leaving a fixation: the window restarts with the current point.
      mem_we    = 1'b1;
      mem_waddr = '0;
    end
    mem_re    = scan_issue;
    mem_raddr = head_q + idx_q[PTR_W-1:0];
  end

  always_ff @(posedge clk_i) begin
    if (mem_we) begin
      ring_mem[mem_waddr] <= mem_wdata;
    end
    if (mem_re) begin
      rd_data_q <= ring_mem[mem_raddr];
    end
  end

  assign div_dividend = (state_q == S_TEST) ? tot_x_q : tot_y_q;

  gfd_div u_div (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (div_start),
    .dividend_i (div_dividend),
    .divisor_i  (count_q),
    .status_o   (div_st),
    .quotient_o (div_quot)
  );

  always_comb begin
    state_d   = state_q;
    x_d       = x_q;
    y_d       = y_q;
    head_d    = head_q;
    count_d   = count_q;
    in_fix_d  = in_fix_q;
    low_x_d   = low_x_q;
    high_x_d  = high_x_q;
    low_y_d   = low_y_q;
    high_y_d  = high_y_q;
    tot_x_d   = tot_x_q;
    tot_y_d   = tot_y_q;
    idx_d     = idx_q;
    first_d   = first_q;
    rd_vld_d  = scan_issue;
    flag_d    = flag_q;
    spread_d  = spread_q;
    cx_d      = cx_q;
    m_valid_d = m_valid_q;
    m_data_d  = m_data_q;
    m_user_d  = m_user_q;
    div_start = 1'b0;

    if (m_valid_q && m_axis_tready) begin
      m_valid_d = 1'b0;
    end

    unique case (state_q)
      S_IDLE: begin
        if (s_axis_tvalid) begin
          x_d      = s_axis_tdata[COORD_W-1:0];
          y_d      = s_axis_tdata[IN_DATA_W-1:COORD_W];
          flag_d   = 1'b0;
          spread_d = '0;
          state_d  = in_fix_q ? S_FIX : S_PUSH;
        end
      end

      S_FIX: begin
        if (x_q < low_x_q)  low_x_d  = x_q;
        if (x_q > high_x_q) high_x_d = x_q;
        if (y_q < low_y_q)  low_y_d  = y_q;
        if (y_q > high_y_q) high_y_d = y_q;
        // Past the saturated count a point still widens the extent only.
        if (count_q != COUNT_MAX) begin
          count_d = count_q + COUNT_W'(1);
          tot_x_d = tot_x_q + SUM_W'(x_q);
          tot_y_d = tot_y_q + SUM_W'(y_q);
        end
        state_d = S_TEST;
      end

      S_PUSH: begin
        head_d  = push_head;
        count_d = COUNT_W'(push_new_cnt);
        idx_d   = '0;
        first_d = 1'b1;
        state_d = (push_new_cnt >= WIN_CNT_W'(minp)) ? S_SCAN : S_DONE;
      end

      S_SCAN: begin
        if (scan_issue) begin
          idx_d = idx_q + WIN_CNT_W'(1);
        end
        if (rd_vld_q) begin
          first_d = 1'b0;
          if (first_q) begin
            low_x_d  = px;
            high_x_d = px;
            low_y_d  = py;
            high_y_d = py;
            tot_x_d  = SUM_W'(px);
            tot_y_d  = SUM_W'(py);
          end else begin
            if (px < low_x_q)  low_x_d  = px;
            if (px > high_x_q) high_x_d = px;
            if (py < low_y_q)  low_y_d  = py;
            if (py > high_y_q) high_y_d = py;
            tot_x_d = tot_x_q + SUM_W'(px);
            tot_y_d = tot_y_q + SUM_W'(py);
          end
        end
        if (!scan_issue && !rd_vld_q) begin
          state_d = S_TEST;
        end
      end

      S_TEST: begin
        if (do_test) begin
          spread_d = range_sum;
          if (spread_ok) begin
            flag_d   = 1'b1;
            in_fix_d = 1'b1;
          end else if (in_fix_q) begin
            in_fix_d = 1'b0;
            head_d   = '0;
            count_d  = COUNT_W'(1);
          end else begin
            head_d  = head_q + PTR_W'(1);
            count_d = count_q - COUNT_W'(1);
          end
        end
        if (in_fix_d) begin
          div_start = 1'b1;
          state_d   = S_DIVX;
        end else begin
          state_d = S_DONE;
        end
      end

      S_DIVX: begin
        if (div_st.done) begin
          cx_d      = div_quot;
          div_start = 1'b1;
          state_d   = S_DIVY;
        end
      end

      S_DIVY: begin
        if (div_st.done) begin
          state_d = S_DONE;
        end
      end

      S_DONE: begin
        // The centroid and size are reported only while a fixation is open.
        if (!m_valid_q || m_axis_tready) begin
          m_valid_d = 1'b1;
          m_user_d  = flag_q;
          m_data_d  = {{PAD_W{1'b0}},
                       in_fix_q ? count_q  : COUNT_W'(0),
                       in_fix_q ? div_quot : COORD_W'(0),
                       in_fix_q ? cx_q     : COORD_W'(0),
                       spread_q};
          state_d   = S_IDLE;
        end
      end

      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= S_IDLE;
      head_q    <= '0;
      count_q   <= '0;
      in_fix_q  <= 1'b0;
      low_x_q   <= '0;
      high_x_q  <= '0;
      low_y_q   <= '0;
      high_y_q  <= '0;
      tot_x_q   <= '0;
      tot_y_q   <= '0;
      idx_q     <= '0;
      first_q   <= 1'b0;
      rd_vld_q  <= 1'b0;
      m_valid_q <= 1'b0;
    end else begin
      state_q   <= state_d;
      head_q    <= head_d;
      count_q   <= count_d;
      in_fix_q  <= in_fix_d;
      low_x_q   <= low_x_d;
      high_x_q  <= high_x_d;
      low_y_q   <= low_y_d;
      high_y_q  <= high_y_d;
      tot_x_q   <= tot_x_d;
      tot_y_q   <= tot_y_d;
      idx_q     <= idx_d;
      first_q   <= first_d;
      rd_vld_q  <= rd_vld_d;
      m_valid_q <= m_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    x_q      <= x_d;
    y_q      <= y_d;
    flag_q   <= flag_d;
    spread_q <= spread_d;
    cx_q     <= cx_d;
    m_data_q <= m_data_d;
    m_user_q <= m_user_d;
  end

  // An open fixation always holds at least one point.
  fix_has_points: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_fix_q |-> count_q != '0)
    else $error("fixation open with an empty cluster");

  // The sliding window never grows past the ring.
  window_in_ring: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !in_fix_q |-> count_q <= COUNT_W'(WINDOW_DEPTH))
    else $error("sliding window exceeds the ring depth");

  // The divider is never running when a new item can be taken.
  idle_div_free: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == S_IDLE |-> !div_st.busy)
    else $error("divider busy while the block is idle");

  // A positive test result always leaves the fixation open.
  flag_means_fix: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_DONE && flag_q) |-> in_fix_q)
    else $error("fixation flagged but not open");

endmodule

// File: verif/gfd_fixation_checker.sv
// Checker for the gaze fixation detector: tracks register writes, predicts one
// result per accepted gaze point and compares results field by field.
// Depends on gfd_pkg for widths, register indexes and reset values.
module gfd_fixation_checker (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           cfg_we_i,
  input  logic [gfd_pkg::CFG_IDX_W-1:0]  cfg_idx_i,
  input  logic [gfd_pkg::CFG_DATA_W-1:0] cfg_data_i,
  input  logic                           s_axis_tvalid,
  input  logic                           s_axis_tready,
  // tdata from bit 0 up: x_coord[15:0], y_coord[31:16]
  input  logic [gfd_pkg::IN_DATA_W-1:0]  s_axis_tdata,
  input  logic                           m_axis_tvalid,
  input  logic                           m_axis_tready,
  // tdata from bit 0 up: spread[16:0], centre_x[32:17], centre_y[48:33],
  // cluster_size[64:49], zero fill[71:65]
  input  logic [gfd_pkg::OUT_DATA_W-1:0] m_axis_tdata,
  // tuser from bit 0 up: is_fixation[0]
  input  logic [0:0]                     m_axis_tuser,
  output int                             pending_o,
  output int                             errors_o
);
  timeunit 1ns;
  timeprecision 1ps;
  import gfd_pkg::*;

  typedef struct packed {
    logic                is_fixation;
    logic [SPREAD_W-1:0] spread;
    logic [COORD_W-1:0]  centre_x;
    logic [COORD_W-1:0]  centre_y;
    logic [COUNT_W-1:0]  cluster_size;
  } gaze_result_t;

  // Tracker state: sliding window ring plus running cluster statistics.
  logic [COORD_W-1:0] win_x [WINDOW_DEPTH];
  logic [COORD_W-1:0] win_y [WINDOW_DEPTH];
  int unsigned        oldest;
  int unsigned        npoints;
  bit                 fixating;
  logic [COORD_W-1:0] lo_x, hi_x, lo_y, hi_y;
  longint unsigned    sum_x, sum_y;
  logic [MINP_W-1:0]  min_points;
  logic [SPREAD_W-1:0] max_disp;

  gaze_result_t owed_results[$];
  int           errors = 0;

  assign errors_o = errors;

  function automatic int unsigned win_slot(int unsigned offset);
    return (oldest + offset) % WINDOW_DEPTH;
  endfunction

  function automatic int unsigned extent();
    return (hi_x - lo_x) + (hi_y - lo_y);
  endfunction

  task automatic widen(input logic [COORD_W-1:0] x, input logic [COORD_W-1:0] y);
    if (x < lo_x) lo_x = x;
    if (x > hi_x) hi_x = x;
    if (y < lo_y) lo_y = y;
    if (y > hi_y) hi_y = y;
  endtask

  task automatic track_gaze(input logic [COORD_W-1:0] x, input logic [COORD_W-1:0] y,
                            output gaze_result_t res);
    int unsigned     need;
    int unsigned     spread;
    bit              hit;
    longint unsigned acc_x, acc_y;
    need   = 32'(min_points);
    spread = 0;
    hit    = 1'b0;
    if (need < 1) need = 1;
    if (need > WINDOW_DEPTH) need = WINDOW_DEPTH;

    if (fixating) begin
      widen(x, y);
      if (npoints < COUNT_MAX) begin
        npoints++;
        sum_x += 64'(x);
        sum_y += 64'(y);
      end
      if (npoints >= need) begin
        spread = extent();
        if (spread > 0 && spread <= max_disp) begin
          hit = 1'b1;
        end else begin
          // Cluster broke up: the window restarts with this point alone.
          fixating = 1'b0;
          oldest   = 0;
          win_x[0] = x;
          win_y[0] = y;
          npoints  = 1;
        end
      end
    end else begin
      if (npoints >= WINDOW_DEPTH) begin
        oldest  = win_slot(1);
        npoints = WINDOW_DEPTH - 1;
      end
      win_x[win_slot(npoints)] = x;
      win_y[win_slot(npoints)] = y;
      npoints++;
      if (npoints >= need) begin
        lo_x  = win_x[win_slot(0)];
        hi_x  = lo_x;
        lo_y  = win_y[win_slot(0)];
        hi_y  = lo_y;
        acc_x = 0;
        acc_y = 0;
        for (int unsigned i = 0; i < npoints; i++) begin
          widen(win_x[win_slot(i)], win_y[win_slot(i)]);
          acc_x += 64'(win_x[win_slot(i)]);
          acc_y += 64'(win_y[win_slot(i)]);
        end
        spread = extent();
        if (spread > 0 && spread <= max_disp) begin
          hit      = 1'b1;
          fixating = 1'b1;
          sum_x    = acc_x;
          sum_y    = acc_y;
        end else begin
          oldest = win_slot(1);
          npoints--;
        end
      end
    end

    res.is_fixation = hit;
    res.spread      = spread[SPREAD_W-1:0];
    if (fixating && npoints > 0) begin
      res.centre_x     = COORD_W'(sum_x / npoints);
      res.centre_y     = COORD_W'(sum_y / npoints);
      res.cluster_size = COUNT_W'(npoints);
    end else begin
      res.centre_x     = '0;
      res.centre_y     = '0;
      res.cluster_size = '0;
    end
  endtask

  task automatic check_field(input string name, input longint unsigned want,
                             input longint unsigned got);
    if (want != got) begin
      $error("%s mismatch: expected %0d, actual %0d", name, want, got);
      errors++;
    end
  endtask

  // Register writes, accepted points and accepted results are all sampled at
  // the rising edge, so they see the values that the block itself sees.
  always @(posedge clk_i or negedge rst_ni) begin : watch
    gaze_result_t want;
    gaze_result_t got;
    if (!rst_ni) begin
      oldest     = 0;
      npoints    = 0;
      fixating   = 1'b0;
      lo_x       = '0;
      hi_x       = '0;
      lo_y       = '0;
      hi_y       = '0;
      sum_x      = 0;
      sum_y      = 0;
      min_points = MINP_RESET;
      max_disp   = MAXD_RESET;
      owed_results.delete();
      pending_o <= 0;
    end else begin
      if (cfg_we_i) begin
        case (cfg_idx_i)
          REG_MIN_POINTS: min_points = cfg_data_i[MINP_W-1:0];
          REG_MAX_DISP:   max_disp   = cfg_data_i[SPREAD_W-1:0];
          default: ;
        endcase
      end
      if (s_axis_tvalid && s_axis_tready) begin
        track_gaze(s_axis_tdata[15:0], s_axis_tdata[31:16], want);
        owed_results.insert(owed_results.size(), want);
      end
      if (m_axis_tvalid && m_axis_tready) begin
        got.is_fixation  = m_axis_tuser[0];
        got.spread       = m_axis_tdata[16:0];
        got.centre_x     = m_axis_tdata[32:17];
        got.centre_y     = m_axis_tdata[48:33];
        got.cluster_size = m_axis_tdata[64:49];
        if (owed_results.size() == 0) begin
          $error("result item arrived with no expectation waiting");
          errors++;
        end else begin
          want = owed_results[0];
          owed_results.delete(0);
          check_field("is_fixation", 64'(want.is_fixation), 64'(got.is_fixation));
          check_field("spread", 64'(want.spread), 64'(got.spread));
          check_field("centre_x", 64'(want.centre_x), 64'(got.centre_x));
          check_field("centre_y", 64'(want.centre_y), 64'(got.centre_y));
          check_field("cluster_size", 64'(want.cluster_size), 64'(got.cluster_size));
        end
      end
      pending_o <= owed_results.size();
    end
  end

endmodule

// File: verif/gaze_fixation_dispersion_detector_test.sv
// Testbench top for the gaze fixation detector: clock, reset, stimulus and verdict.
// Depends on gfd_pkg, the block gaze_fixation_dispersion_detector and the
// checker gfd_fixation_checker, which predicts and compares every result item.
module gaze_fixation_dispersion_detector_test;
  timeunit 1ns;
  timeprecision 1ps;
  import gfd_pkg::*;

  // Input items to send in total, directed part included.
  localparam int TOTAL_POINTS = 1300;
  // Cycle budget for the whole run. The slowest correct run is about 1300
  // items, each at its slowest plus the longest sender gap and the longest
  // receiver stall, well under this limit.
  localparam int CYCLE_LIMIT  = 2_500_000;

  logic                  clk_i         = 1'b0;
  logic                  rst_ni        = 1'b0;
  logic                  cfg_we_i      = 1'b0;
  logic [CFG_IDX_W-1:0]  cfg_idx_i     = REG_MIN_POINTS;
  logic [CFG_DATA_W-1:0] cfg_data_i    = '0;
  logic                  s_axis_tvalid = 1'b0;
  logic                  s_axis_tready;
  logic [IN_DATA_W-1:0]  s_axis_tdata  = '0;
  logic                  m_axis_tvalid;
  logic                  m_axis_tready = 1'b0;
  logic [OUT_DATA_W-1:0] m_axis_tdata;
  logic [0:0]            m_axis_tuser;

  int pending;
  int errors;
  int points_sent = 0;
  int cycles      = 0;

  // When set, neither side idles: the sender has no gaps and the receiver
  // never stalls. Some phases run this way so back-to-back traffic is seen.
  bit steady = 1'b0;

  // The threshold the stimulus currently runs under; the clusters are
  // shaped from it so that many of them actually become fixations.
  logic [SPREAD_W-1:0] cur_disp = MAXD_RESET;

  always #5 clk_i = ~clk_i;

  gaze_fixation_dispersion_detector dut (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cfg_we_i     (cfg_we_i),
    .cfg_idx_i    (cfg_idx_i),
    .cfg_data_i   (cfg_data_i),
    .s_axis_tvalid(s_axis_tvalid),
    .s_axis_tready(s_axis_tready),
    .s_axis_tdata (s_axis_tdata),
    .m_axis_tvalid(m_axis_tvalid),
    .m_axis_tready(m_axis_tready),
    .m_axis_tdata (m_axis_tdata),
    .m_axis_tuser (m_axis_tuser)
  );

  gfd_fixation_checker u_checker (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cfg_we_i     (cfg_we_i),
    .cfg_idx_i    (cfg_idx_i),
    .cfg_data_i   (cfg_data_i),
    .s_axis_tvalid(s_axis_tvalid),
    .s_axis_tready(s_axis_tready),
    .s_axis_tdata (s_axis_tdata),
    .m_axis_tvalid(m_axis_tvalid),
    .m_axis_tready(m_axis_tready),
    .m_axis_tdata (m_axis_tdata),
    .m_axis_tuser (m_axis_tuser),
    .pending_o    (pending),
    .errors_o     (errors)
  );

  // Watchdog: a hung handshake ends the run here.
  always @(posedge clk_i) begin
    cycles <= cycles + 1;
    if (cycles > CYCLE_LIMIT) begin
      $display("TEST FAILED");
      $finish;
    end
  end

  // Receiver back-pressure. Ready is held for runs of random length: mostly
  // short ready or stall runs, now and then a long stall, so stalls land on
  // every phase of the block's work, including while it scans or divides.
  int ready_hold = 0;
  always @(posedge clk_i) begin : receiver
    int unsigned pick;
    if (steady) begin
      m_axis_tready <= 1'b1;
      ready_hold    <= 0;
    end else if (ready_hold > 0) begin
      ready_hold <= ready_hold - 1;
    end else begin
      pick = $urandom_range(0, 99);
      if (pick < 55) begin
        m_axis_tready <= 1'b1;
        ready_hold    <= $urandom_range(0, 12);
      end else if (pick < 94) begin
        m_axis_tready <= 1'b0;
        ready_hold    <= $urandom_range(0, 4);
      end else begin
        m_axis_tready <= 1'b0;
        ready_hold    <= $urandom_range(20, 150);
      end
    end
  end

  function automatic int sender_gap();
    int unsigned pick;
    pick = $urandom_range(0, 99);
    if (steady || pick < 65) return 0;
    if (pick < 94) return $urandom_range(1, 4);
    return $urandom_range(20, 150);
  endfunction

  function automatic logic [COORD_W-1:0] clip(int v);
    if (v < 0) return '0;
    if (v > 65535) return '1;
    return v[COORD_W-1:0];
  endfunction

  // Sends one gaze point. Valid is only lowered when a gap follows, so a
  // valid that stays high for the next item never gets two assignments in
  // one time step. The loop leaves at the edge where the item was accepted.
  task automatic send_point(input logic [COORD_W-1:0] x, input logic [COORD_W-1:0] y);
    int gap;
    gap = sender_gap();
    if (gap > 0) begin
      s_axis_tvalid <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    s_axis_tdata  <= {y, x};
    s_axis_tvalid <= 1'b1;
    do @(posedge clk_i); while (!s_axis_tready);
    points_sent++;
  endtask

  // Waits until every expected result has been taken. The first edge lets
  // the checker count an item accepted at the current edge.
  task automatic wait_drained();
    s_axis_tvalid <= 1'b0;
    @(posedge clk_i);
    while (pending != 0) @(posedge clk_i);
    repeat (4) @(posedge clk_i);
  endtask

  // Both registers are written on consecutive edges, only while the block
  // is idle.
  task automatic write_config(input logic [MINP_W-1:0] minp,
                              input logic [SPREAD_W-1:0] disp);
    cfg_we_i   <= 1'b1;
    cfg_idx_i  <= REG_MIN_POINTS;
    cfg_data_i <= CFG_DATA_W'(minp);
    @(posedge clk_i);
    cfg_idx_i  <= REG_MAX_DISP;
    cfg_data_i <= CFG_DATA_W'(disp);
    @(posedge clk_i);
    cfg_we_i   <= 1'b0;
    cur_disp = disp;
  endtask

  // A fixation: points jittered around a random centre, with the jitter
  // scaled to the threshold so the cluster sometimes holds and sometimes
  // breaks up part way through.
  task automatic send_cluster(input int len);
    int cx, cy, jit;
    cx  = $urandom_range(0, 65535);
    cy  = $urandom_range(0, 65535);
    jit = $urandom_range(0, cur_disp / 3 + 2);
    if (jit > 30000) jit = 30000;
    for (int i = 0; i < len && points_sent < TOTAL_POINTS; i++) begin
      send_point(clip(cx + int'($urandom_range(0, 2 * jit)) - jit),
                 clip(cy + int'($urandom_range(0, 2 * jit)) - jit));
    end
  endtask

  // Smooth pursuit: a slow random walk that drifts out of any cluster.
  task automatic send_drift(input int len);
    int px, py, stride;
    px     = $urandom_range(0, 65535);
    py     = $urandom_range(0, 65535);
    stride = $urandom_range(1, cur_disp / 4 + 2);
    for (int i = 0; i < len && points_sent < TOTAL_POINTS; i++) begin
      px = int'(clip(px + int'($urandom_range(0, 2 * stride)) - stride));
      py = int'(clip(py + int'($urandom_range(0, 2 * stride)) - stride));
      send_point(px[COORD_W-1:0], py[COORD_W-1:0]);
    end
  endtask

  // Saccades and tracker noise: scattered points, some at the field limits.
  task automatic send_noise(input int len);
    logic [COORD_W-1:0] x, y;
    for (int i = 0; i < len && points_sent < TOTAL_POINTS; i++) begin
      x = COORD_W'($urandom_range(0, 65535));
      y = COORD_W'($urandom_range(0, 65535));
      if ($urandom_range(0, 3) == 0) x = $urandom_range(0, 1) ? '1 : '0;
      if ($urandom_range(0, 3) == 0) y = $urandom_range(0, 1) ? '1 : '0;
      send_point(x, y);
    end
  endtask

  // One random phase: a fresh setting, then a mix of fixations, pursuit and
  // noise. Most settings are realistic; some are the extremes of both
  // registers, including a minimum of zero and minimums past the ring depth.
  task automatic random_phase();
    int unsigned pick;
    int          quota, eff;
    logic [MINP_W-1:0]   minp;
    logic [SPREAD_W-1:0] disp;
    pick = $urandom_range(0, 99);
    if (pick < 8) minp = MINP_W'($urandom_range(0, 1));
    else if (pick < 14) minp = MINP_W'(64);
    else if (pick < 20) minp = MINP_W'($urandom_range(65, 127));
    else if (pick < 30) minp = MINP_W'($urandom_range(13, 63));
    else minp = MINP_W'($urandom_range(2, 12));
    pick = $urandom_range(0, 99);
    if (pick < 6) disp = '0;
    else if (pick < 12) disp = 17'd131070;
    else if (pick < 24) disp = SPREAD_W'($urandom_range(0, 131071));
    else disp = SPREAD_W'($urandom_range(40, 4000));

    wait_drained();
    write_config(minp, disp);
    steady <= ($urandom_range(0, 3) == 0);

    eff   = (minp < 1) ? 1 : (minp > WINDOW_DEPTH) ? WINDOW_DEPTH : int'(minp);
    quota = points_sent + $urandom_range(20, 120);
    while (points_sent < quota && points_sent < TOTAL_POINTS) begin
      pick = $urandom_range(0, 99);
      if (pick < 60) send_cluster($urandom_range(2, eff + 20));
      else if (pick < 75) send_drift($urandom_range(5, 30));
      else send_noise($urandom_range(1, 4));
    end
  endtask

  initial begin
    repeat (5) @(posedge clk_i);
    rst_ni <= 1'b1;

    // Reset setting (six points, 800): a tight cluster of six points becomes
    // a fixation on the sixth.
    for (int i = 0; i < 6; i++) send_point(16'(800 + 3 * i), 16'(400 + 2 * i));

    // A minimum of one at the widest threshold: the open fixation absorbs
    // both field corners, whose spread of 131070 is still within the limit.
    wait_drained();
    write_config(7'd1, 17'd131070);
    send_point('0, '0);
    send_point('1, '1);

    // A minimum of zero behaves like one.
    wait_drained();
    write_config(7'd0, 17'd131070);
    send_point('1, '0);

    // A minimum of two keeps the cluster going at the largest spread.
    wait_drained();
    write_config(7'd2, 17'd131070);
    send_point('0, '0);
    send_point('1, '1);
    send_point('0, '1);

    // Minimum raised past the cluster size while in a fixation: the point is
    // absorbed, the test is skipped and the centroid is still reported.
    wait_drained();
    write_config(7'd100, 17'd131070);
    send_point(16'd12345, 16'd54321);

    // A threshold of zero breaks the cluster and restarts the window; then
    // two equal points give zero spread, which is never a fixation.
    wait_drained();
    write_config(7'd2, 17'd0);
    send_point(16'd1, 16'd1);
    send_point(16'd1, 16'd1);

    // Spread exactly at a threshold of one is a fixation, one more is not.
    wait_drained();
    write_config(7'd3, 17'd1);
    send_point(16'd1, 16'd2);
    send_point(16'd1, 16'd1);
    send_point(16'd2, 16'd1);

    while (points_sent < TOTAL_POINTS) random_phase();

    // Drain, then give the block more than the length of its slowest item
    // to show any result that should not exist.
    wait_drained();
    steady <= 1'b1;
    repeat (150) @(posedge clk_i);
    if (errors == 0 && pending == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end

endmodule

// File: gaze_fixation_dispersion_detector.f
hdl/gfd_pkg.sv
hdl/gfd_div.sv
hdl/gaze_fixation_dispersion_detector.sv
verif/gfd_fixation_checker.sv
verif/gaze_fixation_dispersion_detector_test.sv
